FILE: rtl/conv3x3_replicate_border_core_macros.svh
// assertion macros for the 3x3 convolution core checker
`ifndef CONV3X3_REPLICATE_BORDER_CORE_MACROS_SVH
`define CONV3X3_REPLICATE_BORDER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define C3RB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define C3RB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/c3rb_pkg.sv
// ----------------------------------------------------------------------------
// c3rb_pkg
// Types and fixed constants shared by the 3x3 convolution core.
// ----------------------------------------------------------------------------
package c3rb_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int ROW_BITS       = 16;
    localparam int OUT_BITS       = 24;
    localparam int OUT_COL_BITS   = 11;
    localparam int PROD_BITS      = PIXEL_BITS + 1 + COEF_BITS;
    localparam int SUM_BITS       = PROD_BITS + 4;
    localparam int ROUND_BIAS     = (COEF_FRAC_BITS > 0) ? (1 << (COEF_FRAC_BITS - 1)) : 0;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 3 * COEF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT      = 3'd4;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef t_pix [8:0] t_win;
    typedef logic [CFG_DATA_BITS-1:0] t_coef_row;

    typedef struct packed {
        logic top_edge;
        logic left_edge;
        logic last_col;
        logic last_row;
    } t_flags;

endpackage

FILE: rtl/conv3x3_replicate_border_core.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_core
// 3x3 convolution of a raster pixel stream with replicated image border.
//
//   channel   direction  payload
//   in        sink       pixel_in
//   out       source     pixel_out, out_row, out_col, last_of_run, end_of_image
//   cfg       sink       cfg_index, cfg_data (always ready)
//
// one pixel per cycle in while the queue has room; one result per cycle out of
// the multiply pipe unless the output stalls; a pixel and its line-store reads
// are registered, then its job is queued; results run product, sum, output regs
// row ends give up to four results per pixel, absorbed by the job queue
// synchronous active-low reset; line stores are not cleared
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_core #(
    parameter int MAX_WIDTH = 2048,
    parameter int QDEPTH    = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [15:0]                              i_pixel_in,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [c3rb_pkg::OUT_BITS-1:0]     o_pixel_out,
    output logic [c3rb_pkg::ROW_BITS-1:0]            o_out_row,
    output logic [c3rb_pkg::OUT_COL_BITS-1:0]        o_out_col,
    output logic                                     o_last_of_run,
    output logic                                     o_end_of_image,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [c3rb_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [c3rb_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import c3rb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int QW  = 9 * PIXEL_BITS + $bits(t_flags) + ROW_BITS + CW;

    t_coef_row     r_coef_top, r_coef_mid, r_coef_bot;
    logic [11:0]   r_width;
    logic [15:0]   r_height;
    logic [13:0]   width_x;
    logic [13:0]   last_col_x;
    logic [CW-1:0] last_col;
    logic [ROW_BITS-1:0] last_row;
    logic          cfg_we;

    logic                 push, pop, q_valid;
    logic [$clog2(QDEPTH):0] q_level;
    t_win                 f_win, b_win;
    t_flags               f_flags, b_flags;
    logic [ROW_BITS-1:0]  f_row, b_row;
    logic [CW-1:0]        f_col, b_col;
    logic [QW-1:0]        q_in, q_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= CFG_DATA_BITS'(48'h0000_1000_0000);
            r_coef_bot <= '0;
            r_width    <= 12'd2048;
            r_height   <= 16'd1024;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_COEF_TOP:    r_coef_top <= i_cfg_data;
                CFG_COEF_MID:    r_coef_mid <= i_cfg_data;
                CFG_COEF_BOTTOM: r_coef_bot <= i_cfg_data;
                CFG_WIDTH:       r_width    <= i_cfg_data[11:0];
                CFG_HEIGHT:      r_height   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // width limited to two..MAX_WIDTH, height to at least two
    assign width_x    = {2'b00, r_width};
    assign last_col_x = (width_x < 14'd2) ? 14'd1 :
                        (width_x > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH - 1) : width_x - 14'd1;
    assign last_col   = CW'(last_col_x);
    assign last_row   = (r_height < 16'd2) ? 16'd1 : r_height - 16'd1;

    c3rb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .QDEPTH    (QDEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel_in[PIXEL_BITS-1:0]),
        .i_last_col (last_col),
        .i_last_row (last_row),
        .i_q_level  (q_level),
        .o_push     (push),
        .o_win      (f_win),
        .o_flags    (f_flags),
        .o_row      (f_row),
        .o_col      (f_col)
    );

    assign q_in = {f_win, f_flags, f_row, f_col};
    assign {b_win, b_flags, b_row, b_col} = q_out;

    c3rb_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_level (q_level)
    );

    c3rb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_win          (b_win),
        .i_flags        (b_flags),
        .i_row          (b_row),
        .i_col          (b_col),
        .o_pop          (pop),
        .i_coef_top     (r_coef_top),
        .i_coef_mid     (r_coef_mid),
        .i_coef_bot     (r_coef_bot),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_image (o_end_of_image)
    );

endmodule

FILE: rtl/c3rb_queue.sv
// ----------------------------------------------------------------------------
// c3rb_queue
// Small job queue between the window front end and the filter back end.
// ----------------------------------------------------------------------------
module c3rb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic                     o_valid,
    output logic [WIDTH-1:0]         o_data,
    output logic [$clog2(DEPTH):0]   o_level
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_level;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_level != '0);
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_level <= r_level + (AW + 1)'(i_push) - (AW + 1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/c3rb_front.sv
// ----------------------------------------------------------------------------
// c3rb_front
// Takes pixels, keeps the line stores and window, and queues filter jobs.
// ----------------------------------------------------------------------------
module c3rb_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int QDEPTH    = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  c3rb_pkg::t_pix                    i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_last_col,
    input  logic [c3rb_pkg::ROW_BITS-1:0]     i_last_row,
    input  logic [$clog2(QDEPTH):0]           i_q_level,
    output logic                              o_push,
    output c3rb_pkg::t_win                    o_win,
    output c3rb_pkg::t_flags                  o_flags,
    output logic [c3rb_pkg::ROW_BITS-1:0]     o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col
);
    import c3rb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(QDEPTH) + 1;

    t_pix r_old_line [MAX_WIDTH];
    t_pix r_new_line [MAX_WIDTH];

    logic [CW-1:0]       r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [CW-1:0]       cur_col;
    logic [ROW_BITS-1:0] cur_row;
    logic                accept;
    logic [LW:0]         used;

    logic                r_b_v;
    logic                r_b_emit;
    t_pix                r_b_pix;
    logic [CW-1:0]       r_b_col;
    logic [ROW_BITS-1:0] r_b_row;
    t_flags              r_b_flags;
    t_pix                r_rd_old, r_rd_new;
    t_win                r_win, n_win;

    assign used       = {1'b0, i_q_level} + (LW + 1)'(r_b_v);
    assign o_in_ready = (used < (LW + 1)'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;

    assign cur_col = (r_col > i_last_col) ? i_last_col : r_col;
    assign cur_row = (r_row > i_last_row) ? i_last_row : r_row;

    always_comb begin
        if (cur_col >= i_last_col) begin
            n_col = '0;
            n_row = (cur_row >= i_last_row) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix             <= i_pixel;
            r_b_col             <= cur_col;
            r_b_row             <= cur_row;
            r_b_emit            <= (cur_row != '0) && (cur_col != '0);
            r_b_flags.top_edge  <= (cur_row == ROW_BITS'(1));
            r_b_flags.left_edge <= (cur_col == CW'(1));
            r_b_flags.last_col  <= (cur_col == i_last_col);
            r_b_flags.last_row  <= (cur_row == i_last_row);
        end
    end

    // line stores, read at accept and written back in the cycle after it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_old <= r_old_line[cur_col];
            r_rd_new <= r_new_line[cur_col];
        end
        if (r_b_v) begin
            r_old_line[r_b_col] <= r_rd_new;
            r_new_line[r_b_col] <= r_b_pix;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i * 3]     = r_win[i * 3 + 1];
            n_win[i * 3 + 1] = r_win[i * 3 + 2];
        end
        n_win[2] = r_rd_old;
        n_win[5] = r_rd_new;
        n_win[8] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_b_v) begin
            r_win <= n_win;
        end
    end

    assign o_push  = r_b_v && r_b_emit;
    assign o_win   = n_win;
    assign o_flags = r_b_flags;
    assign o_row   = r_b_row;
    assign o_col   = r_b_col;

endmodule

FILE: rtl/c3rb_back.sv
// ----------------------------------------------------------------------------
// c3rb_back
// Expands each job into its results and runs the multiply-accumulate pipe.
// ----------------------------------------------------------------------------
module c3rb_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  c3rb_pkg::t_win                       i_win,
    input  c3rb_pkg::t_flags                     i_flags,
    input  logic [c3rb_pkg::ROW_BITS-1:0]        i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_col,
    output logic                                 o_pop,
    input  c3rb_pkg::t_coef_row                  i_coef_top,
    input  c3rb_pkg::t_coef_row                  i_coef_mid,
    input  c3rb_pkg::t_coef_row                  i_coef_bot,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [c3rb_pkg::OUT_BITS-1:0] o_pixel_out,
    output logic [c3rb_pkg::ROW_BITS-1:0]        o_out_row,
    output logic [c3rb_pkg::OUT_COL_BITS-1:0]    o_out_col,
    output logic                                 o_last_of_run,
    output logic                                 o_end_of_image
);
    import c3rb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    localparam logic [1:0] PH_UP_PREV  = 2'd0;
    localparam logic [1:0] PH_UP_EDGE  = 2'd1;
    localparam logic [1:0] PH_LOW_PREV = 2'd2;
    localparam logic [1:0] PH_LOW_EDGE = 2'd3;

    logic       en, fire, is_last;
    logic [1:0] r_ph, n_ph;
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    t_coef_row  coefs [3];

    logic                        r1_v, r2_v, r_o_v;
    logic signed [PROD_BITS-1:0] r1_prod [9];
    logic [ROW_BITS-1:0]         r1_row, r2_row, r_o_row;
    logic [CW-1:0]               r1_col, r2_col, r_o_col;
    logic                        r1_last, r2_last, r_o_last;
    logic                        r1_eoi, r2_eoi, r_o_eoi;
    logic signed [SUM_BITS-1:0]  r2_sum [3];
    logic signed [SUM_BITS-1:0]  total;
    logic signed [OUT_BITS-1:0]  r_o_pix;

    assign en   = !r_o_v || i_out_ready;
    assign fire = en && i_q_valid;

    assign coefs[0] = i_coef_top;
    assign coefs[1] = i_coef_mid;
    assign coefs[2] = i_coef_bot;

    always_comb begin
        is_last = 1'b0;
        n_ph    = PH_UP_PREV;
        case (r_ph)
            PH_UP_PREV: begin
                if (i_flags.last_col) begin
                    n_ph = PH_UP_EDGE;
                end else if (i_flags.last_row) begin
                    n_ph = PH_LOW_PREV;
                end else begin
                    is_last = 1'b1;
                end
            end
            PH_UP_EDGE: begin
                if (i_flags.last_row) begin
                    n_ph = PH_LOW_PREV;
                end else begin
                    is_last = 1'b1;
                end
            end
            PH_LOW_PREV: begin
                if (i_flags.last_col) begin
                    n_ph = PH_LOW_EDGE;
                end else begin
                    is_last = 1'b1;
                end
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    assign o_pop = fire && is_last;

    // replicated border: pick window rows and columns for this result
    always_comb begin
        if (r_ph[1]) begin
            rs[0] = 2'd1;
            rs[1] = 2'd2;
            rs[2] = 2'd2;
        end else begin
            rs[0] = i_flags.top_edge ? 2'd1 : 2'd0;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
        end
        if (r_ph[0]) begin
            cs[0] = 2'd1;
            cs[1] = 2'd2;
            cs[2] = 2'd2;
        end else begin
            cs[0] = i_flags.left_edge ? 2'd1 : 2'd0;
            cs[1] = 2'd1;
            cs[2] = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_UP_PREV;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r1_v  <= fire;
            r2_v  <= r1_v;
            r_o_v <= r2_v;
            if (fire) begin
                r_ph <= is_last ? PH_UP_PREV : n_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_prod[i * 3 + j] <=
                        $signed({1'b0, i_win[4'(rs[i]) * 4'd3 + 4'(cs[j])]})
                        * $signed(coefs[i][j * COEF_BITS +: COEF_BITS]);
                end
            end
            r1_row  <= r_ph[1] ? i_row : i_row - 1'b1;
            r1_col  <= r_ph[0] ? i_col : i_col - 1'b1;
            r1_last <= is_last;
            r1_eoi  <= (r_ph == PH_LOW_EDGE);

            for (int i = 0; i < 3; i++) begin
                r2_sum[i] <= SUM_BITS'(r1_prod[i * 3]) + SUM_BITS'(r1_prod[i * 3 + 1])
                           + SUM_BITS'(r1_prod[i * 3 + 2]);
            end
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_last <= r1_last;
            r2_eoi  <= r1_eoi;

            r_o_pix  <= OUT_BITS'(total >>> COEF_FRAC_BITS);
            r_o_row  <= r2_row;
            r_o_col  <= r2_col;
            r_o_last <= r2_last;
            r_o_eoi  <= r2_eoi;
        end
    end

    assign total = r2_sum[0] + r2_sum[1] + r2_sum[2] + SUM_BITS'(ROUND_BIAS);

    assign o_out_valid    = r_o_v;
    assign o_pixel_out    = r_o_pix;
    assign o_out_row      = r_o_row;
    assign o_out_col      = OUT_COL_BITS'(r_o_col);
    assign o_last_of_run  = r_o_last;
    assign o_end_of_image = r_o_eoi;

endmodule

FILE: rtl/c3rb_checker.sv
// ----------------------------------------------------------------------------
// c3rb_checker
// Port-level checks on the 3x3 convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_replicate_border_core_macros.svh"

module c3rb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_last_of_run,
    input logic        o_end_of_image,
    input logic [10:0] o_out_col
);

    `C3RB_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `C3RB_ASSERT_NOW(a_eoi_last, o_out_valid && o_end_of_image, o_last_of_run, "eoi not last")
    `C3RB_ASSERT_NOW(a_eoi_col, o_out_valid && o_end_of_image, o_out_col != 11'd0, "eoi col 0")
    `C3RB_ASSERT_NOW(a_reset_idle, $past(!i_rst_n), !o_out_valid && o_in_ready, "busy after reset")

endmodule

bind conv3x3_replicate_border_core c3rb_checker u_c3rb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_last_of_run  (o_last_of_run),
    .o_end_of_image (o_end_of_image),
    .o_out_col      (o_out_col)
);
